// ===== hw/rtl/pdq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the positional deque: sizes, mode and status codes, cell control.
// No dependencies; used by the channel interfaces, the cell and the top level.
package pdq_pkg;

  // Storage geometry
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Fixed beat field widths
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Width wide enough to compare a position against the count plus one
  localparam int unsigned CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 4'd0,
    MODE_PUSH_FRONT = 4'd1,
    MODE_POP_BACK   = 4'd2,
    MODE_POP_FRONT  = 4'd3,
    MODE_PEEK_BACK  = 4'd4,
    MODE_PEEK_FRONT = 4'd5,
    MODE_PEEK_POS   = 4'd6,
    MODE_INSERT     = 4'd7,
    MODE_DELETE     = 4'd8
  } pdq_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } pdq_status_e;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } pdq_op_e;

  // Control broadcast along the chain
  typedef struct packed {
    pdq_op_e               op;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [DATA_WIDTH-1:0] din;
  } pdq_ctrl_t;

endpackage

// ===== hw/rtl/pdq_intf.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result beats.
// Depends on pdq_pkg for field widths.
interface pdq_in_if;
  import pdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] data_in;

  modport source (output valid, output mode, output position, output data_in, input ready);
  modport sink   (input valid, input mode, input position, input data_in, output ready);
endinterface

interface pdq_out_if;
  import pdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output data_out, output status, output count, input ready);
  modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

// ===== hw/rtl/pdq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the deque chain: holds one word and trades with its neighbors.
// Depends on pdq_pkg for the control struct and widths.
module pdq_cell (
  input  logic                           clk_i,
  input  pdq_pkg::pdq_ctrl_t             ctrl_i,
  input  logic [pdq_pkg::IDX_W-1:0]      idx_i,
  input  logic [pdq_pkg::DATA_WIDTH-1:0] prev_i,
  input  logic [pdq_pkg::DATA_WIDTH-1:0] next_i,
  output logic [pdq_pkg::DATA_WIDTH-1:0] data_o,
  output logic [pdq_pkg::DATA_WIDTH-1:0] rd_o
);
  import pdq_pkg::*;

  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] word_d;

  // Shift toward the back on insert, toward the front on delete
  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (idx_i == ctrl_i.idx) begin
          word_d = ctrl_i.din;
        end else if (idx_i > ctrl_i.idx) begin
          word_d = prev_i;
        end
      end
      OP_DELETE: begin
        if (idx_i >= ctrl_i.idx) begin
          word_d = next_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Drive the read bus only when addressed
  assign rd_o   = (idx_i == ctrl_i.rd_idx) ? word_q : '0;
  assign data_o = word_q;

endmodule

// ===== hw/rtl/positional_deque_core.sv =====
`timescale 1ns / 1ps
// Top level of the positional deque: request decode, element count, cell chain, result register.
// Depends on pdq_pkg, pdq_intf (pdq_in_if, pdq_out_if) and pdq_cell.
//
//  channel | dir | fields                      | beat rule
//  in_i    | in  | mode, position, data_in     | valid && ready
//  out_o   | out | data_out, status, count     | valid && ready
//
// For each taken request the whole cell chain shifts in parallel, and the result
// is captured in the output register at the same edge.
// in_i.ready is high whenever the output register is empty or being drained,
// so one beat per cycle flows while out_o.ready stays high.
// Reset clears the element count and the output valid; cell contents stay undefined.
module positional_deque_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  pdq_in_if.sink    in_i,
  pdq_out_if.source out_o
);
  import pdq_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;

  logic                out_valid_q;
  logic [WORD_W-1:0]   out_data_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic accept;
  logic full;
  logic empty;
  logic in_range;
  logic ins_range;
  logic use_read;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] last_ext;
  logic [CMP_W-1:0] posm1_ext;

  pdq_ctrl_t   ctrl;
  pdq_status_e status;
  logic [63:0] din_wide;
  logic [63:0] rd_wide;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_word;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  assign full      = (cnt_q == CNT_W'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign pos_ext   = CMP_W'(in_i.position);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign last_ext  = cnt_ext - CMP_W'(1);
  assign posm1_ext = pos_ext - CMP_W'(1);
  assign in_range  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign ins_range = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));

  // Keep the low data bits of the incoming word
  assign din_wide = 64'(in_i.data_in);

  // Decode the request into a chain operation, status and new count
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.idx    = '0;
    ctrl.rd_idx = '0;
    ctrl.din    = din_wide[DATA_WIDTH-1:0];
    status      = ST_OK;
    use_read    = 1'b0;
    cnt_d       = cnt_q;
    case (pdq_mode_e'(in_i.mode))
      MODE_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op  = OP_INSERT;
          ctrl.idx = cnt_ext[IDX_W-1:0];
          cnt_d    = cnt_q + CNT_W'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = OP_INSERT;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status = ST_NOT_FOUND;
        end else begin
          ctrl.op     = OP_DELETE;
          ctrl.idx    = last_ext[IDX_W-1:0];
          ctrl.rd_idx = last_ext[IDX_W-1:0];
          use_read    = 1'b1;
          cnt_d       = cnt_q - CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status = ST_NOT_FOUND;
        end else begin
          ctrl.op  = OP_DELETE;
          use_read = 1'b1;
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end
      MODE_PEEK_BACK: begin
        if (empty) begin
          status = ST_NOT_FOUND;
        end else begin
          ctrl.rd_idx = last_ext[IDX_W-1:0];
          use_read    = 1'b1;
        end
      end
      MODE_PEEK_FRONT: begin
        if (empty) begin
          status = ST_NOT_FOUND;
        end else begin
          use_read = 1'b1;
        end
      end
      MODE_PEEK_POS: begin
        if (!in_range) begin
          status = ST_NOT_FOUND;
        end else begin
          ctrl.rd_idx = posm1_ext[IDX_W-1:0];
          use_read    = 1'b1;
        end
      end
      MODE_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (!ins_range) begin
          status = ST_NOT_FOUND;
        end else begin
          ctrl.op  = OP_INSERT;
          ctrl.idx = posm1_ext[IDX_W-1:0];
          cnt_d    = cnt_q + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (!in_range) begin
          status = ST_NOT_FOUND;
        end else begin
          ctrl.op     = OP_DELETE;
          ctrl.idx    = posm1_ext[IDX_W-1:0];
          ctrl.rd_idx = posm1_ext[IDX_W-1:0];
          use_read    = 1'b1;
          cnt_d       = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    // Only a taken beat moves the chain
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // Cell chain, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = cell_data[i+1];
    end
    pdq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .idx_i  (IDX_W'(i)),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // Merge the read bus; at most one cell drives it
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_wide = 64'(rd_word);

  // Element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // Result register: hold until drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= use_read ? rd_wide[WORD_W-1:0] : '0;
      out_status_q <= status;
      out_count_q  <= COUNT_W'(cnt_d);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.status   = out_status_q;
  assign out_o.count    = out_count_q;

endmodule

// ===== tb/deque_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the positional deque: watches request and result beats, keeps its own
// copy of the stored sequence, predicts every result and compares it field by field.
// Depends on pdq_pkg and the channel interfaces pdq_in_if / pdq_out_if.
module deque_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdq_in_if           req_mon_i,
  pdq_out_if          rsp_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned level_o
);
  import pdq_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  data;
    pdq_status_e        status;
    logic [COUNT_W-1:0] count;
  } deque_result_t;

  // Front of the sequence sits at index 0
  logic [DATA_WIDTH-1:0] words_q[$];
  deque_result_t         expect_q[$];
  int unsigned           mismatches = 0;

  // Apply one request to the shadow sequence and return the result it must produce
  function automatic deque_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                  input logic [POS_W-1:0]  pos,
                                                  input logic [WORD_W-1:0] din);
    deque_result_t         res;
    logic                  full;
    logic                  empty;
    logic                  pos_hit;
    logic [DATA_WIDTH-1:0] w;
    res     = '0;
    w       = DATA_WIDTH'(din);
    full    = words_q.size() >= DEPTH;
    empty   = words_q.size() == 0;
    pos_hit = (pos >= 1) && (pos <= words_q.size());
    res.status = ST_OK;
    case (mode)
      MODE_PUSH_BACK: begin
        if (full) res.status = ST_FULL;
        else words_q.push_back(w);
      end
      MODE_PUSH_FRONT: begin
        if (full) res.status = ST_FULL;
        else words_q.push_front(w);
      end
      MODE_POP_BACK: begin
        if (empty) res.status = ST_NOT_FOUND;
        else res.data = WORD_W'(words_q.pop_back());
      end
      MODE_POP_FRONT: begin
        if (empty) res.status = ST_NOT_FOUND;
        else res.data = WORD_W'(words_q.pop_front());
      end
      MODE_PEEK_BACK: begin
        if (empty) res.status = ST_NOT_FOUND;
        else res.data = WORD_W'(words_q[words_q.size() - 1]);
      end
      MODE_PEEK_FRONT: begin
        if (empty) res.status = ST_NOT_FOUND;
        else res.data = WORD_W'(words_q[0]);
      end
      MODE_PEEK_POS: begin
        if (!pos_hit) res.status = ST_NOT_FOUND;
        else res.data = WORD_W'(words_q[pos - 1]);
      end
      MODE_INSERT: begin
        // Full check wins over the position check; count + 1 appends
        if (full) res.status = ST_FULL;
        else if (pos == 0 || pos > words_q.size() + 1) res.status = ST_NOT_FOUND;
        else words_q.insert(pos - 1, w);
      end
      MODE_DELETE: begin
        if (!pos_hit) res.status = ST_NOT_FOUND;
        else begin
          res.data = WORD_W'(words_q[pos - 1]);
          words_q.delete(pos - 1);
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(words_q.size());
    return res;
  endfunction

  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni) begin
      // Retire the result beat first: it belongs to a request from an earlier edge
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (expect_q.size() == 0) begin
          $error("result beat with no request outstanding: data_out=%h status=%0d count=%0d",
                 rsp_mon_i.data_out, rsp_mon_i.status, rsp_mon_i.count);
          mismatches++;
        end else begin
          want = expect_q.pop_front();
          if (rsp_mon_i.data_out !== want.data) begin
            $error("data_out: expected %h, got %h", want.data, rsp_mon_i.data_out);
            mismatches++;
          end
          if (rsp_mon_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_mon_i.status);
            mismatches++;
          end
          if (rsp_mon_i.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp_mon_i.count);
            mismatches++;
          end
        end
      end
      // Predict the request beat taken on this edge
      if (req_mon_i.valid && req_mon_i.ready) begin
        expect_q.push_back(apply_request(req_mon_i.mode, req_mon_i.position,
                                         req_mon_i.data_in));
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expect_q.size();
    level_o        <= words_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the positional deque testbench: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Depends on pdq_pkg, pdq_intf, positional_deque_core, deque_scoreboard.
module tb_top;
  import pdq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 4'd9;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 4'd15;
  localparam logic [POS_W-1:0]  POS_MAX           = '1;
  localparam int unsigned ITEMS_PER_PHASE = 360;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES    = 4;

  typedef enum int { BIAS_FILL, BIAS_DRAIN, BIAS_MIXED } fill_bias_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned stored_level;
  int unsigned quiet_cycles   = 0;

  pdq_in_if  req_if ();
  pdq_out_if rsp_if ();

  positional_deque_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  deque_scoreboard u_scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon_i      (req_if),
    .rsp_mon_i      (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .level_o        (stored_level)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random back-pressure on the result channel
  always @(posedge clk_i) begin
    if (rst_ni) rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one request beat, idling first at random, and hold it until taken
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [POS_W-1:0]  position,
                              input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.position <= position;
    req_if.data_in  <= word;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // One random request, leaning toward growing or shrinking the sequence
  task automatic send_random(input fill_bias_e bias);
    int unsigned       r;
    int unsigned       grow_w;
    int unsigned       shrink_w;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    case (bias)
      BIAS_FILL:  begin grow_w = 62; shrink_w = 14; end
      BIAS_DRAIN: begin grow_w = 14; shrink_w = 62; end
      default:    begin grow_w = 38; shrink_w = 38; end
    endcase
    r = $urandom_range(0, 99);
    if (r < 4) begin
      mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    end else if (r < 4 + grow_w) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_PUSH_BACK;
        1:       mode = MODE_PUSH_FRONT;
        default: mode = MODE_INSERT;
      endcase
    end else if (r < 4 + grow_w + shrink_w) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_POP_BACK;
        1:       mode = MODE_POP_FRONT;
        default: mode = MODE_DELETE;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_PEEK_BACK;
        1:       mode = MODE_PEEK_FRONT;
        default: mode = MODE_PEEK_POS;
      endcase
    end
    // Mostly positions that hit the sequence or its append slot, some anywhere
    if ($urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(1, stored_level + 1));
    else pos = POS_W'($urandom_range(0, POS_MAX));
    case ($urandom_range(0, 15))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    send_request(mode, pos, word);
  endtask

  initial begin
    int unsigned issued;
    int unsigned chunk_len;
    int unsigned chunk_idx;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_PUSH_BACK;
    req_if.position = '0;
    req_if.data_in  = '0;
    rsp_if.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty store: every removal, peek and bad insert must be refused
    send_request(MODE_POP_BACK,   7'd0, 32'h0);
    send_request(MODE_POP_FRONT,  7'd0, 32'h0);
    send_request(MODE_PEEK_BACK,  7'd0, 32'h0);
    send_request(MODE_PEEK_FRONT, 7'd0, 32'h0);
    send_request(MODE_PEEK_POS,   7'd1, 32'h0);
    send_request(MODE_DELETE,     7'd1, 32'h0);
    send_request(MODE_INSERT,     7'd2, 32'hDEAD_BEEF);
    send_request(MODE_INSERT,     7'd0, 32'hDEAD_BEEF);
    // Build a short sequence at both ends and in the middle
    send_request(MODE_PUSH_BACK,  7'd0, 32'hFFFF_FFFF);
    send_request(MODE_PUSH_FRONT, 7'd0, 32'h0000_0000);
    send_request(MODE_INSERT,     7'd3, 32'h5A5A_A5A5);
    send_request(MODE_INSERT,     7'd2, 32'h1234_5678);
    // Peeks in and out of range
    send_request(MODE_PEEK_POS,   7'd0, 32'h0);
    send_request(MODE_PEEK_POS,   7'd5, 32'h0);
    send_request(MODE_PEEK_POS,   7'd4, 32'h0);
    send_request(MODE_PEEK_POS,   POS_MAX, 32'h0);
    send_request(MODE_PEEK_FRONT, 7'd0, 32'h0);
    send_request(MODE_PEEK_BACK,  7'd0, 32'h0);
    // Removals, with unused modes in between
    send_request(MODE_DELETE,     POS_MAX, 32'h0);
    send_request(MODE_DELETE,     7'd2, 32'h0);
    send_request(MODE_UNUSED_LAST,  POS_MAX, 32'hFFFF_FFFF);
    send_request(MODE_UNUSED_FIRST, 7'd1, 32'hA5A5_5A5A);
    send_request(MODE_POP_BACK,   7'd0, 32'h0);
    send_request(MODE_POP_FRONT,  7'd0, 32'h0);
    send_request(MODE_DELETE,     7'd1, 32'h0);

    // Random part: four pacing phases, each in chunks that fill, drain or mix
    chunk_idx = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      issued = 0;
      while (issued < ITEMS_PER_PHASE) begin
        chunk_len = $urandom_range(100, 140);
        repeat (chunk_len) send_random(fill_bias_e'(chunk_idx % 3));
        issued += chunk_len;
        chunk_idx++;
      end
    end
    req_if.valid <= 1'b0;

    // Wait for every outstanding result, then let the pipeline settle
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
